/* rtl/fcau_pkg.sv */
// Package: opcodes, cell width and shared constants for the cell arithmetic unit.
`default_nettype none
package fcau_pkg;
  localparam int CELL_BITS_DEF = 16;
  localparam int DIV_STAGES = 4;

  typedef enum logic [3:0] {
    OP_UMUL  = 4'd0,
    OP_UDIV  = 4'd1,
    OP_DADD  = 4'd2,
    OP_DNEG  = 4'd3,
    OP_ADD   = 4'd4,
    OP_NEG   = 4'd5,
    OP_AND   = 4'd6,
    OP_OR    = 4'd7,
    OP_XOR   = 4'd8,
    OP_ZEQ   = 4'd9,
    OP_ZLT   = 4'd10,
    OP_SEXT  = 4'd11,
    OP_DIGIT = 4'd12
  } op_t;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] ALPHA_GAP = 8'd17;
  localparam logic [7:0] ALPHA_ADJ = 8'd7;
endpackage
`default_nettype wire

/* rtl/fcau_mul.sv */
// Pipelined unsigned cell multiplier: operands split into halves, partial products summed.
`default_nettype none
module fcau_mul #(
  parameter int CB = fcau_pkg::CELL_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic [CB-1:0]   a,
  input  wire logic [CB-1:0]   b,
  output logic      [2*CB-1:0] prod
);
  import fcau_pkg::*;
  localparam int HB = CB / 2;
  localparam int LB = CB - HB;

  logic [2*LB-1:0] p00_r;
  logic [LB+HB-1:0] p01_r, p10_r;
  logic [2*HB-1:0] p11_r;
  logic [2*CB-1:0] sum_r;

  // register partial products, then add them
  always_ff @(posedge clk) begin
    p00_r <= a[LB-1:0] * b[LB-1:0];
    p01_r <= a[LB-1:0] * b[CB-1:LB];
    p10_r <= a[CB-1:LB] * b[LB-1:0];
    p11_r <= a[CB-1:LB] * b[CB-1:LB];
    sum_r <= (2*CB)'(p00_r) + ((2*CB)'(p01_r) << LB) + ((2*CB)'(p10_r) << LB)
           + ((2*CB)'(p11_r) << (2*LB));
  end
  assign prod = sum_r;
endmodule
`default_nettype wire

/* rtl/fcau_div.sv */
// Pipelined restoring divider: CB quotient bits spread over DIV_STAGES registered stages.
`default_nettype none
module fcau_div #(
  parameter int CB = fcau_pkg::CELL_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic [CB-1:0] num_hi,
  input  wire logic [CB-1:0] num_lo,
  input  wire logic [CB-1:0] divisor,
  output logic      [CB-1:0] rem,
  output logic      [CB-1:0] quo
);
  import fcau_pkg::*;
  localparam int NS = DIV_STAGES;
  localparam int BPS = (CB + NS - 1) / NS;

  logic [CB-1:0] r_r [NS+1];
  logic [CB-1:0] q_r [NS+1];
  logic [CB-1:0] v_r [NS+1];
  logic          ovf_r [NS+1];

  // stage zero captures operands and the overflow check
  always_ff @(posedge clk) begin
    r_r[0]   <= num_hi;
    q_r[0]   <= num_lo;
    v_r[0]   <= divisor;
    ovf_r[0] <= (num_hi >= divisor);
  end

  // each stage retires up to BPS quotient bits
  for (genvar s = 0; s < NS; s++) begin : g_stage
    always_ff @(posedge clk) begin
      logic [CB-1:0] r, q;
      logic          c;
      r = r_r[s];
      q = q_r[s];
      for (int i = 0; i < BPS; i++) begin
        if (s * BPS + i < CB) begin
          c = r[CB-1];
          r = {r[CB-2:0], q[CB-1]};
          q = {q[CB-2:0], 1'b0};
          if (c || r >= v_r[s]) begin
            r = r - v_r[s];
            q[0] = 1'b1;
          end
        end
      end
      r_r[s+1]   <= r;
      q_r[s+1]   <= q;
      v_r[s+1]   <= v_r[s];
      ovf_r[s+1] <= ovf_r[s];
    end
  end

  assign rem = ovf_r[NS] ? '1 : r_r[NS];
  assign quo = ovf_r[NS] ? '1 : q_r[NS];
endmodule
`default_nettype wire

/* rtl/fcau_simple.sv */
// Combinational logic for add, negate, logic, flags, sign extension and digit conversion.
`default_nettype none
module fcau_simple #(
  parameter int CB = fcau_pkg::CELL_BITS_DEF
) (
  input  wire logic [3:0]    op,
  input  wire logic [CB-1:0] t,
  input  wire logic [CB-1:0] s,
  input  wire logic [CB-1:0] u,
  input  wire logic [CB-1:0] f,
  output logic      [CB-1:0] first,
  output logic      [CB-1:0] second,
  output logic      [1:0]    count
);
  import fcau_pkg::*;
  logic [2*CB-1:0] dsum, dneg;
  logic [7:0]      c0, c1;
  logic            dig_ok;

  assign dsum = {t, s} + {u, f};
  assign dneg = '0 - {t, s};

  // digit conversion on the low byte
  always_comb begin
    c0 = s[7:0] - CHAR_ZERO;
    c1 = (c0 > 8'd9) ? c0 - ALPHA_ADJ : c0;
    dig_ok = (s[7:0] >= CHAR_ZERO) && !((c0 > 8'd9) && (c0 < ALPHA_GAP))
             && (c1 < t[7:0]);
  end

  always_comb begin
    first  = '0;
    second = '0;
    count  = 2'd1;
    case (op)
      OP_DADD: begin
        first = dsum[CB-1:0]; second = dsum[2*CB-1:CB]; count = 2'd2;
      end
      OP_DNEG: begin
        first = dneg[CB-1:0]; second = dneg[2*CB-1:CB]; count = 2'd2;
      end
      OP_ADD:  first = t + s;
      OP_NEG:  first = '0 - t;
      OP_AND:  first = t & s;
      OP_OR:   first = t | s;
      OP_XOR:  first = t ^ s;
      OP_ZEQ:  first = CB'(t == '0);
      OP_ZLT:  first = CB'(t[CB-1]);
      OP_SEXT: begin
        first = t; second = {CB{t[CB-1]}}; count = 2'd2;
      end
      OP_DIGIT: begin
        if (dig_ok) begin
          first = CB'(c1); second = CB'(1); count = 2'd2;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/forth_cell_arithmetic_unit.sv */
// Top level: Forth cell arithmetic unit with pipelined multiply and divide.
// Every opcode passes through the same pipeline from start to out_valid; its depth is set by DIV_STAGES.
// Throughput: one operation per cycle; busy is never raised.
// The receiver cannot stall; each result shows for one cycle with out_valid.
// Reset (rst_n low, synchronous) clears the valid pipeline; data registers are not reset.
`default_nettype none
module forth_cell_arithmetic_unit #(
  parameter int CELL_BITS = fcau_pkg::CELL_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [3:0]           in_op,
  input  wire logic [CELL_BITS-1:0] in_top_cell,
  input  wire logic [CELL_BITS-1:0] in_second_cell,
  input  wire logic [CELL_BITS-1:0] in_third_cell,
  input  wire logic [CELL_BITS-1:0] in_fourth_cell,
  output logic                      out_valid,
  output logic [CELL_BITS-1:0]      out_push_first,
  output logic [CELL_BITS-1:0]      out_push_second,
  output logic [1:0]                out_push_count
);
  import fcau_pkg::*;
  localparam int LAT = DIV_STAGES + 2;
  localparam int MLAT = 2;

  logic [CELL_BITS-1:0] s_first, s_second, rem, quo;
  logic [CELL_BITS-1:0] rem_r, quo_r;
  logic [1:0]           s_count;
  logic [2*CELL_BITS-1:0] prod;

  logic                 v_r  [LAT];
  logic [3:0]           op_r [LAT];
  logic [CELL_BITS-1:0] f_r  [LAT];
  logic [CELL_BITS-1:0] s_r  [LAT];
  logic [1:0]           c_r  [LAT];
  logic [2*CELL_BITS-1:0] prod_r [LAT-MLAT];

  assign busy = 1'b0;

  fcau_simple #(.CB(CELL_BITS)) u_simple (
    .op(in_op), .t(in_top_cell), .s(in_second_cell), .u(in_third_cell),
    .f(in_fourth_cell), .first(s_first), .second(s_second), .count(s_count)
  );
  fcau_mul #(.CB(CELL_BITS)) u_mul (
    .clk(clk), .a(in_top_cell), .b(in_second_cell), .prod(prod)
  );
  fcau_div #(.CB(CELL_BITS)) u_div (
    .clk(clk), .num_hi(in_second_cell), .num_lo(in_third_cell),
    .divisor(in_top_cell), .rem(rem), .quo(quo)
  );

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) v_r[i] <= 1'b0;
    end else begin
      v_r[0] <= start;
      for (int i = 1; i < LAT; i++) v_r[i] <= v_r[i-1];
    end
  end

  // advance op and simple results alongside
  always_ff @(posedge clk) begin
    op_r[0] <= in_op;
    f_r[0]  <= s_first;
    s_r[0]  <= s_second;
    c_r[0]  <= s_count;
    for (int i = 1; i < LAT; i++) begin
      op_r[i] <= op_r[i-1];
      f_r[i]  <= f_r[i-1];
      s_r[i]  <= s_r[i-1];
      c_r[i]  <= c_r[i-1];
    end
    prod_r[0] <= prod;
    for (int i = 1; i < LAT - MLAT; i++) prod_r[i] <= prod_r[i-1];
    // hold divider result one stage to line up with the valid bits
    rem_r <= rem;
    quo_r <= quo;
  end

  // select final result
  always_comb begin
    out_valid       = v_r[LAT-1];
    out_push_first  = f_r[LAT-1];
    out_push_second = s_r[LAT-1];
    out_push_count  = c_r[LAT-1];
    case (op_r[LAT-1])
      OP_UMUL: begin
        out_push_first  = prod_r[LAT-MLAT-1][CELL_BITS-1:0];
        out_push_second = prod_r[LAT-MLAT-1][2*CELL_BITS-1:CELL_BITS];
        out_push_count  = 2'd2;
      end
      OP_UDIV: begin
        out_push_first  = rem_r;
        out_push_second = quo_r;
        out_push_count  = 2'd2;
      end
      default: ;
    endcase
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_push_count == 2'd1 || out_push_count == 2'd2))
    else $error("push count out of range");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] |-> ##(LAT-1) out_valid)
    else $error("result lost in pipeline");
  a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_push_count == 2'd1) |-> out_push_second == '0)
    else $error("single result with nonzero second cell");
endmodule
`default_nettype wire
